// File: design/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table: word layouts, action
// and status codes, and the control and flag bundles between the cells.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VAL_W         = 32;
  localparam int POS_W         = 9;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] occupancy;
  } out_word_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

  // compare flags a cell reports, all masked by its active state
  typedef struct packed {
    logic lt;
    logic le;
    logic eq;
  } cell_flag_t;

endpackage

// File: design/sorted_list_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Ascending table of signed keys with insert, remove and find, built as a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one command word: action
//   (insert, remove first equal, find) and a signed 32-bit value.
//   res channel (res_valid/res_ready/res) returns exactly one word per
//   command: status, 1-based position of a found key, and occupancy.
//   Each command is taken into an input stage, then executed: every cell
//   compares its key with the command key at once, and on a successful insert
//   or remove the row shifts by one slot. The result lands in an output
//   register, so a word reaches res through the input stage and then the
//   output register, and one command per cycle is sustained while res_ready
//   stays high. The path that sets the clock is the 32-bit compare in each
//   cell followed by the one-hot position select across the row.
//   When res_ready is low the result holds, one more command is taken into
//   the input stage, and then cmd_ready drops until the result is taken.
//   Reset empties the table (occupancy zero) and drops any pending word;
//   the block accepts commands in the first cycle after reset.
// ----------------------------------------------------------------------------
module sorted_list_table_core #(
  parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  slt_pkg::in_word_t  cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output slt_pkg::out_word_t res
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

  logic                    op_valid;
  in_word_t                op;
  logic                    fire;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  cell_cmd_t               cell_cmd;
  out_word_t               res_next;
  logic signed [VAL_W-1:0] ent [DEPTH];
  cell_flag_t              flag [DEPTH];
  logic [DEPTH-1:0]        lt_vec;
  logic [DEPTH-1:0]        le_vec;
  logic [DEPTH-1:0]        eq_vec;
  logic                    hit;
  logic [POS_W-1:0]        pos_sel;

  // input stage and execute handshake
  assign fire      = op_valid && (!res_valid || res_ready);
  assign cmd_ready = !op_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (cmd_ready) begin
      op_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      op <= cmd;
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b0;
      assign left_val = op.value;
    end else begin : g_left
      assign left_lt  = lt_vec[i-1];
      assign left_val = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = ent[i];
    end else begin : g_right
      assign right_val = ent[i+1];
    end

    slt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .key       (op.value),
      .count     (count),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .entry     (ent[i]),
      .flag      (flag[i])
    );

    assign lt_vec[i] = flag[i].lt;
    assign le_vec[i] = flag[i].le;
    assign eq_vec[i] = flag[i].eq;
  end

  assign hit = |eq_vec;

  // position of the first entry not below the key, one-hot select
  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (le_vec[i] && (i == 0 || !le_vec[(i == 0) ? 0 : i - 1])) begin
        pos_sel = pos_sel | POS_W'(i + 1);
      end
    end
  end

  // action decode
  always_comb begin
    cell_cmd       = '0;
    count_next     = count;
    res_next       = '0;
    res_next.status = ST_DONE;
    case (op.action)
      ACT_INSERT: begin
        if (count == FULL_C) begin
          res_next.status = ST_FULL;
        end else begin
          cell_cmd.ins = fire;
          count_next   = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (count == '0) begin
          res_next.status = ST_EMPTY;
        end else if (!hit) begin
          res_next.status = ST_ABSENT;
        end else begin
          cell_cmd.rem = fire;
          count_next   = count - CNT_W'(1);
        end
      end
      ACT_FIND: begin
        if (count == '0) begin
          res_next.status = ST_EMPTY;
        end else if (!hit) begin
          res_next.status = ST_ABSENT;
        end else begin
          res_next.position = pos_sel;
        end
      end
      default: begin
        res_next.status = ST_DONE;
      end
    endcase
    res_next.occupancy = POS_W'(count_next);
  end

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_C)
    else $error("fill level above table depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> count == $past(count))
    else $error("fill level changed without a command");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    cell_cmd.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> ent[0] <= ent[1])
    else $error("first two entries out of order");

  a_pos_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.position != '0 |->
      res.status == ST_DONE && res.position <= res.occupancy)
    else $error("position reported without a successful find");
`endif

endmodule

// File: design/slt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the table: holds a key, compares it with the broadcast key
// and takes its left or right neighbor's key when the list shifts.
// ----------------------------------------------------------------------------
module slt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                             clk,
  input  slt_pkg::cell_cmd_t               cmd,
  input  logic signed [slt_pkg::VAL_W-1:0] key,
  input  logic [CNT_W-1:0]                 count,
  input  logic                             left_lt,
  input  logic signed [slt_pkg::VAL_W-1:0] left_val,
  input  logic signed [slt_pkg::VAL_W-1:0] right_val,
  output logic signed [slt_pkg::VAL_W-1:0] entry,
  output slt_pkg::cell_flag_t              flag
);
  import slt_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic active;
  logic at_end;

  // slot position relative to the fill level
  assign active = (IDX_C < count);
  assign at_end = (IDX_C == count);

  // compares against the broadcast key, only inside the filled part
  assign flag.lt = active & (key < entry);
  assign flag.le = active & (key <= entry);
  assign flag.eq = active & (key == entry);

  // insert shifts right from the slot, remove shifts left from the match
  always_ff @(posedge clk) begin
    if (cmd.ins && (flag.lt || at_end)) begin
      entry <= left_lt ? left_val : key;
    end else if (cmd.rem && flag.le) begin
      entry <= right_val;
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_list_table_core. A directed table covers the
// empty, full, absent and duplicate cases and the unused action code, then
// phases of random commands with shifting insert bias keep the table moving
// between empty and full. Every result word is checked in order against a
// sorted-queue model of the table, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import slt_pkg::*;

  localparam int TABLE_DEPTH   = DEPTH_DEFAULT;
  localparam int PIPE_LATENCY  = 2;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 10_000_000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    in_word_t  cmd_word;
    bit        fixed;
    out_word_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  in_word_t  cmd;
  logic      res_valid;
  logic      res_ready;
  out_word_t res;

  // sorted copy of the table and result words still owed by the block
  logic signed [31:0] held_keys[$];
  out_word_t          expected_words[$];
  stim_row_t          stim_rows[$];
  int                 mismatch_count = 0;
  bit                 send_idle_on;
  bit                 recv_idle_on;

  sorted_list_table_core #(.DEPTH(TABLE_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #6 clk = ~clk;

  // idle length: mostly short, sometimes medium, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 2);
    if (r < 98) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap();
    if (!send_idle_on || $urandom_range(0, 1) == 0) return 0;
    return idle_len() + 1;
  endfunction

  // apply one command to the table copy and return the word it yields
  function automatic out_word_t apply_cmd(in_word_t w);
    out_word_t o;
    int        slot;
    o = '0;
    o.status = ST_DONE;
    case (w.action)
      ACT_INSERT: begin
        if (held_keys.size() >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot = held_keys.size();
          for (int i = 0; i < held_keys.size(); i++) begin
            if (w.value < held_keys[i]) begin
              slot = i;
              break;
            end
          end
          held_keys.insert(slot, w.value);
        end
      end
      ACT_REMOVE, ACT_FIND: begin
        if (held_keys.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          slot = -1;
          for (int i = 0; i < held_keys.size(); i++) begin
            if (held_keys[i] == w.value) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) o.status = ST_ABSENT;
          else if (w.action == ACT_REMOVE) held_keys.delete(slot);
          else o.position = POS_W'(slot + 1);
        end
      end
      default: ;
    endcase
    o.occupancy = POS_W'(held_keys.size());
    return o;
  endfunction

  // keys: favor held ones so removes and finds hit, plus near-zero duplicates
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && held_keys.size() > 0)
      return held_keys[$urandom_range(0, held_keys.size() - 1)];
    if (r < 75) return $signed($urandom_range(0, 16)) - 8;
    if (r < 95) return $signed($urandom());
    return r[0] ? KEY_MIN : KEY_MAX;
  endfunction

  function automatic void add_row(logic [1:0] act, logic signed [31:0] key, bit fixed = 0,
                                  logic [1:0] st = ST_DONE, int pos = 0, int occ = 0);
    stim_row_t row;
    row.cmd_word = in_word_t'{action: act, value: key};
    row.fixed    = fixed;
    row.want     = out_word_t'{status: st, position: POS_W'(pos), occupancy: POS_W'(occ)};
    stim_rows.push_back(row);
  endfunction

  // present one word, hold it until taken, then log what it should produce
  task automatic send_cmd(in_word_t w, bit use_fixed, out_word_t fixed_want, int gap);
    out_word_t predicted;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!(cmd_valid && cmd_ready));
    predicted = apply_cmd(w);
    expected_words.push_back(use_fixed ? fixed_want : predicted);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // result side: random stalls on res_ready
  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!recv_idle_on || $urandom_range(0, 3) != 0) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk) begin : res_check
    out_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word, status", -1, res.status);
      end else begin
        want = expected_words.pop_front();
        if (res.status != want.status) note_mismatch("status", want.status, res.status);
        if (res.position != want.position)
          note_mismatch("position", want.position, res.position);
        if (res.occupancy != want.occupancy)
          note_mismatch("occupancy", want.occupancy, res.occupancy);
      end
    end
  end

  // stimulus
  initial begin
    int        ins_bias [PHASES] = '{70, 30, 55, 85, 15, 50};
    int        done_items;
    int        r;
    in_word_t  w;
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // empty table, unused code, extremes, duplicates, absent keys
    add_row(ACT_FIND,   32'sd5, 1, ST_EMPTY, 0, 0);
    add_row(ACT_REMOVE, 32'sd5, 1, ST_EMPTY, 0, 0);
    add_row(ACT_UNUSED, 32'sd0, 1, ST_DONE, 0, 0);
    add_row(ACT_INSERT, KEY_MIN, 1, ST_DONE, 0, 1);
    add_row(ACT_INSERT, KEY_MAX, 1, ST_DONE, 0, 2);
    add_row(ACT_INSERT, 32'sd0);
    add_row(ACT_INSERT, 32'sd0);
    add_row(ACT_FIND,   KEY_MIN, 1, ST_DONE, 1, 4);
    add_row(ACT_FIND,   32'sd7, 1, ST_ABSENT, 0, 4);
    add_row(ACT_REMOVE, 32'sd7, 1, ST_ABSENT, 0, 4);
    add_row(ACT_REMOVE, 32'sd0);
    // fill to capacity, then overflow and hit both ends
    for (int i = 0; i < TABLE_DEPTH - 3; i++) add_row(ACT_INSERT, (i - 6) * 100003);
    add_row(ACT_INSERT, 32'sd9, 1, ST_FULL, 0, TABLE_DEPTH);
    add_row(ACT_FIND,   KEY_MAX, 1, ST_DONE, TABLE_DEPTH, TABLE_DEPTH);
    add_row(ACT_REMOVE, KEY_MIN, 1, ST_DONE, 0, TABLE_DEPTH - 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      send_cmd(stim_rows[i].cmd_word, stim_rows[i].fixed, stim_rows[i].want, next_gap());
    wait_drained();

    // random phases; phase 0 runs with no idling on either side
    for (int p = 0; p < PHASES; p++) begin
      send_idle_on = (p != 0) && (p != 3);
      recv_idle_on = (p != 0) && (p != 2);
      done_items   = 0;
      while (done_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 2) w.action = ACT_UNUSED;
        else if (r < 2 + ins_bias[p]) w.action = ACT_INSERT;
        else w.action = r[0] ? ACT_REMOVE : ACT_FIND;
        w.value = pick_key();
        send_cmd(w, 1'b0, '0, next_gap());
        if (w.action != ACT_UNUSED) done_items++;
      end
      wait_drained();
    end

    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
